### src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while in reset.
`define DCLS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked check that also holds during reset.
`define DCLS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

### src/dcls_pkg.sv
// ----------------------------------------------------------------------------
// dcls_pkg
// Types, codes and constants for dimmer channel level selection.
// ----------------------------------------------------------------------------
`default_nettype none

package dcls_pkg;

	localparam int CHANNELS_DEF = 48;

	localparam int CH_W     = 6;
	localparam int DMX_W    = 8;
	localparam int PCT_W    = 7;
	localparam int CURVE_W  = 3;
	localparam int CMD_W    = 2;
	localparam int LVL_W    = 16;
	localparam int CNT_W    = 7;
	localparam int CH_SPACE = 2 ** CH_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORKLIGHT_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LAST_ENABLE = 2'd2;

	localparam logic [CURVE_W-1:0] CURVE_OFF    = 3'd0;
	localparam logic [CURVE_W-1:0] CURVE_LINEAR = 3'd1;
	localparam logic [CURVE_W-1:0] CURVE_SQUARE = 3'd2;
	localparam logic [CURVE_W-1:0] CURVE_SCURVE = 3'd3;
	localparam logic [CURVE_W-1:0] CURVE_SWITCH = 3'd4;
	localparam logic [CURVE_W-1:0] CURVE_ON     = 3'd5;

	localparam logic [CMD_W-1:0] ID_KEEP  = 2'd0;
	localparam logic [CMD_W-1:0] ID_START = 2'd1;
	localparam logic [CMD_W-1:0] ID_STOP  = 2'd2;

	localparam logic [CNT_W-1:0] ID_LOAD     = 7'd100;
	localparam logic [CNT_W-1:0] ID_HIGH_MIN = 7'd50;
	localparam logic [CNT_W-1:0] ID_RELOAD   = 7'd2;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [DMX_W-1:0] DMX_FULL = 8'd255;

	localparam logic [LVL_W-1:0] LVL_FULL     = 16'hFFFF;
	localparam logic [LVL_W-1:0] LVL_HALF     = 16'h8000;
	localparam logic [LVL_W-1:0] ID_DMX_HIGH  = 16'd46260;
	localparam logic [LVL_W-1:0] ID_DMX_LOW   = 16'd19532;
	localparam logic [LVL_W-1:0] ID_MAN_HIGH  = 16'd45875;
	localparam logic [LVL_W-1:0] ID_MAN_LOW   = 16'd19661;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic [DMX_W-1:0]   xlr_value;
		logic [DMX_W-1:0]   eth_value;
		logic               dmx_present;
		logic [PCT_W-1:0]   manual_percent;
		logic [CURVE_W-1:0] curve_mode;
		logic               worklight_flag;
		logic [CMD_W-1:0]   identify_command;
	} item_in_t;

	typedef struct packed {
		logic [CH_W-1:0]  out_channel;
		logic [LVL_W-1:0] level_in;
		logic [LVL_W-1:0] level_out;
	} item_out_t;

	typedef struct packed {
		logic manual_mode;
		logic worklight_enable;
		logic hold_last_enable;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [DMX_W-1:0] held;
	} slot_t;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic [LVL_W-1:0]   level;
		logic [CURVE_W-1:0] curve;
	} lvl_t;

endpackage

`default_nettype wire

### src/dcls_if.sv
// ----------------------------------------------------------------------------
// dcls_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcls_in_if;
	logic               valid;
	logic               ready;
	dcls_pkg::item_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dcls_out_if;
	logic                valid;
	logic                ready;
	dcls_pkg::item_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/dcls_ram.sv
// ----------------------------------------------------------------------------
// dcls_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/dcls_state.sv
// ----------------------------------------------------------------------------
// dcls_state
// Per-channel state read-modify-write and level selection (stage 1).
// ----------------------------------------------------------------------------
`default_nettype none

module dcls_state #(
	parameter int CHANNELS = dcls_pkg::CHANNELS_DEF,
	parameter int DEPTH    = dcls_pkg::CHANNELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dcls_pkg::cfg_t     cfg,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire dcls_pkg::item_in_t in_item,
	output      logic               lvl_valid,
	input  wire logic               lvl_ready,
	output      dcls_pkg::lvl_t     lvl
);

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SLOT_W  = $bits(dcls_pkg::slot_t);
	localparam int LIM_W   = dcls_pkg::CH_W + 1;
	localparam int PX_W    = dcls_pkg::PCT_W + dcls_pkg::LVL_W;
	localparam int RCP_W   = 24;
	localparam int RCP_SH  = 30;
	localparam int PP_W    = PX_W + RCP_W;
	localparam logic [LIM_W-1:0] LIMIT =
		LIM_W'((CHANNELS < dcls_pkg::CH_SPACE) ? CHANNELS : dcls_pkg::CH_SPACE);
	// ceil(2^30 / 100), exact for the percentage range
	localparam logic [RCP_W-1:0] PCT_RCP = 24'd10737419;
	localparam logic [PX_W-1:0]  PCT_RND = 23'd50;

	logic               v_s1;
	dcls_pkg::item_in_t item_s1;
	logic [DEPTH-1:0]   vld_q;
	logic               fwd_v_q;
	logic [AW-1:0]      fwd_addr_q;
	dcls_pkg::slot_t    fwd_data_q;

	logic                        accept;
	logic                        advance;
	logic                        ok;
	logic                        we;
	logic [AW-1:0]               addr_s1;
	logic [SLOT_W-1:0]           rdata;
	dcls_pkg::slot_t             cur;
	dcls_pkg::slot_t             nxt;
	logic [dcls_pkg::CNT_W-1:0]  cnt;
	logic [dcls_pkg::CNT_W-1:0]  cnt_dec;
	logic [dcls_pkg::DMX_W-1:0]  dv;
	logic [dcls_pkg::LVL_W-1:0]  lv;
	logic [PX_W-1:0]             px;
	logic [PP_W-1:0]             pprod;
	logic [dcls_pkg::LVL_W-1:0]  pct_lv;

	assign in_ready = !v_s1 || lvl_ready;
	assign accept   = in_valid && in_ready;
	assign advance  = v_s1 && lvl_ready;
	assign ok       = {1'b0, item_s1.channel} < LIMIT;
	assign addr_s1  = item_s1.channel[AW-1:0];
	assign we       = advance && ok;

	dcls_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (nxt),
		.re    (accept),
		.raddr (in_item.channel[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			vld_q   <= '0;
			fwd_v_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (we) begin
				vld_q[addr_s1] <= 1'b1;
				fwd_v_q        <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
		if (we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= nxt;
		end
	end

	// round(p * 65535 / 100) by reciprocal
	assign px     = {item_s1.manual_percent, 16'd0} - PX_W'(item_s1.manual_percent) + PCT_RND;
	assign pprod  = PP_W'(px) * PP_W'(PCT_RCP);
	assign pct_lv = pprod[RCP_SH +: dcls_pkg::LVL_W];

	always_comb begin
		if (!ok) begin
			cur = '0;
		end else if (fwd_v_q && fwd_addr_q == addr_s1) begin
			cur = fwd_data_q;
		end else if (vld_q[addr_s1]) begin
			cur = dcls_pkg::slot_t'(rdata);
		end else begin
			cur = '0;
		end

		case (item_s1.identify_command)
			dcls_pkg::ID_START: cnt = dcls_pkg::ID_LOAD;
			dcls_pkg::ID_STOP:  cnt = '0;
			default:            cnt = cur.count;
		endcase

		cnt_dec  = cnt - 7'd1;
		nxt.held = cur.held;
		nxt.count = cnt;
		dv       = '0;

		if (cnt != '0) begin
			if (cfg.manual_mode) begin
				lv = (cnt > dcls_pkg::ID_HIGH_MIN) ?
					dcls_pkg::ID_MAN_HIGH : dcls_pkg::ID_MAN_LOW;
			end else begin
				lv = (cnt > dcls_pkg::ID_HIGH_MIN) ?
					dcls_pkg::ID_DMX_HIGH : dcls_pkg::ID_DMX_LOW;
			end
			nxt.count = (cnt_dec <= dcls_pkg::ID_RELOAD) ? dcls_pkg::ID_LOAD : cnt_dec;
		end else if (cfg.manual_mode) begin
			lv = (item_s1.manual_percent >= dcls_pkg::PCT_FULL) ? dcls_pkg::LVL_FULL : pct_lv;
		end else begin
			if (item_s1.dmx_present) begin
				dv = (item_s1.xlr_value > item_s1.eth_value) ?
					item_s1.xlr_value : item_s1.eth_value;
				nxt.held = dv;
			end else if (cfg.worklight_enable && item_s1.worklight_flag) begin
				dv = dcls_pkg::DMX_FULL;
			end else if (cfg.hold_last_enable) begin
				dv = cur.held;
			end
			// v * 257
			lv = {dv, dv};
		end
	end

	assign lvl_valid   = v_s1;
	assign lvl.channel = item_s1.channel;
	assign lvl.level   = lv;
	assign lvl.curve   = item_s1.curve_mode;

endmodule

`default_nettype wire

### src/dcls_curve.sv
// ----------------------------------------------------------------------------
// dcls_curve
// Dimmer curve pipeline: square multiply, divide by full scale, output word.
// ----------------------------------------------------------------------------
`default_nettype none

module dcls_curve (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                lvl_valid,
	output      logic                lvl_ready,
	input  wire dcls_pkg::lvl_t      lvl,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      dcls_pkg::item_out_t out_item
);

	localparam int SQ_W = 2 * dcls_pkg::LVL_W;
	localparam int R_W  = dcls_pkg::LVL_W + 1;
	localparam logic [SQ_W-1:0] SQ_RND  = 32'd32767;
	localparam logic [R_W-1:0]  DIV_ONE = 17'd65535;
	localparam logic [R_W-1:0]  DIV_TWO = 17'd131070;

	logic                       v_s2;
	logic                       v_s3;
	logic                       out_valid_q;
	dcls_pkg::lvl_t             lvl_s2;
	dcls_pkg::lvl_t             lvl_s3;
	logic [SQ_W-1:0]            sq_s3;
	dcls_pkg::item_out_t        out_q;

	logic                       en_o;
	logic                       en3;
	logic                       en2;
	logic [SQ_W-1:0]            y;
	logic [dcls_pkg::LVL_W-1:0] q0;
	logic [R_W-1:0]             r;
	logic [R_W-1:0]             sq_q;
	logic [dcls_pkg::LVL_W-1:0] curved;

	assign en_o      = !out_valid_q || out_ready;
	assign en3       = !v_s3 || en_o;
	assign en2       = !v_s2 || en3;
	assign lvl_ready = en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en2) begin
				v_s2 <= lvl_valid;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_o) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && lvl_valid) begin
			lvl_s2 <= lvl;
		end
		if (en3 && v_s2) begin
			lvl_s3 <= lvl_s2;
			sq_s3  <= SQ_W'(lvl_s2.level) * SQ_W'(lvl_s2.level);
		end
		if (en_o && v_s3) begin
			out_q.out_channel <= lvl_s3.channel;
			out_q.level_in    <= lvl_s3.level;
			out_q.level_out   <= curved;
		end
	end

	// (L*L + 32767) / 65535: quotient by high half, then up to two corrections
	assign y    = sq_s3 + SQ_RND;
	assign q0   = y[SQ_W-1 -: dcls_pkg::LVL_W];
	assign r    = {1'b0, y[dcls_pkg::LVL_W-1:0]} + {1'b0, q0};
	assign sq_q = {1'b0, q0} + R_W'(r >= DIV_ONE) + R_W'(r >= DIV_TWO);

	always_comb begin
		case (lvl_s3.curve)
			dcls_pkg::CURVE_OFF:    curved = '0;
			dcls_pkg::CURVE_SQUARE: curved = sq_q[dcls_pkg::LVL_W-1:0];
			dcls_pkg::CURVE_SWITCH: curved = (lvl_s3.level >= dcls_pkg::LVL_HALF) ?
				dcls_pkg::LVL_FULL : '0;
			dcls_pkg::CURVE_ON:     curved = dcls_pkg::LVL_FULL;
			default:                curved = lvl_s3.level;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

### src/dimmer_channel_level_select.sv
// ----------------------------------------------------------------------------
// dimmer_channel_level_select
// HTP merge, hold-last, worklight, identify blink and dimmer curve per channel.
// ----------------------------------------------------------------------------
// Takes one channel word per clock and returns one result word per clock while
// the result side is ready. The per-channel identify count and held DMX value
// live in one RAM with a registered read: the read is issued as a word is
// accepted, modified in stage 1 and written back as the word leaves stage 1,
// with a one-entry bypass for back-to-back words on the same channel. Entry
// valid flags clear with reset, so the block is usable straight out of reset
// with no clearing pass. Stages 2 and 3 hold the square curve multiply and
// the divide by full scale. Registers must be written through the cfg port
// only while no word is in flight; the block does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module dimmer_channel_level_select #(
	parameter int CHANNELS = dcls_pkg::CHANNELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [dcls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dcls_pkg::CFG_DATA_W-1:0] cfg_data,
	dcls_in_if.sink                              chan,
	dcls_out_if.source                           result
);

	localparam int DEPTH = (CHANNELS < dcls_pkg::CH_SPACE) ? CHANNELS : dcls_pkg::CH_SPACE;

	dcls_pkg::cfg_t cfg_q;
	logic           lvl_valid;
	logic           lvl_ready;
	dcls_pkg::lvl_t lvl;
	logic           curve_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dcls_pkg::CFG_MANUAL_MODE:      cfg_q.manual_mode      <= cfg_data[0];
				dcls_pkg::CFG_WORKLIGHT_ENABLE: cfg_q.worklight_enable <= cfg_data[0];
				dcls_pkg::CFG_HOLD_LAST_ENABLE: cfg_q.hold_last_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	dcls_state #(
		.CHANNELS (CHANNELS),
		.DEPTH    (DEPTH)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (chan.valid),
		.in_ready  (chan.ready),
		.in_item   (chan.payload),
		.lvl_valid (lvl_valid),
		.lvl_ready (lvl_ready),
		.lvl       (lvl)
	);

	dcls_curve u_curve (
		.clk       (clk),
		.arst_n    (arst_n),
		.lvl_valid (lvl_valid),
		.lvl_ready (lvl_ready),
		.lvl       (lvl),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_item  (result.payload)
	);

	// every curve gives no more than its input, or full scale
	assign curve_ok = (result.payload.level_out <= result.payload.level_in) ||
		(result.payload.level_out == dcls_pkg::LVL_FULL);

	// an empty output register means the whole pipe moves
	`DCLS_ASSERT(a_ready_when_out_empty, !result.valid |-> chan.ready, "input stalled")

	`DCLS_ASSERT_ALWAYS(a_no_word_in_reset, !arst_n |-> !result.valid, "result word during reset")

	`DCLS_ASSERT(a_curve_bound, result.valid |-> curve_ok, "curve above input level")

endmodule

`default_nettype wire

### test/tb_dimmer_channel_level_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dimmer_channel_level_select
// Self-checking bench for the dimmer channel level selector.
// ----------------------------------------------------------------------------
// Channel words go in over a valid/ready link and every accepted word is run
// through a scoreboard that keeps its own per-channel identify counts and held
// DMX values. Result words are checked field by field in order. A directed
// pass covers the merge extremes, every curve, identify, manual percentages
// and out-of-range channels. Random phases then sweep the register settings
// with biased channels and long identify runs, with random idling on both
// sides and one phase with none.
// ----------------------------------------------------------------------------

import dcls_pkg::*;

class level_scoreboard;
	cfg_t             cfg;
	logic [CNT_W-1:0] id_count [CHANNELS_DEF];
	logic [DMX_W-1:0] held_dmx [CHANNELS_DEF];
	item_out_t        expected_levels [$];
	int               errors;
	int               checked;

	function new();
		cfg = '0;
		foreach (id_count[i]) begin
			id_count[i] = '0;
			held_dmx[i] = '0;
		end
		errors = 0;
		checked = 0;
	endfunction

	function item_out_t compute_level(item_in_t w);
		item_out_t       r;
		bit              in_range;
		int unsigned     cnt;
		int unsigned     held;
		int unsigned     dv;
		int unsigned     lv;
		longint unsigned sq;
		in_range = (32'(w.channel) < CHANNELS_DEF);
		cnt = in_range ? 32'(id_count[w.channel]) : 32'd0;
		held = in_range ? 32'(held_dmx[w.channel]) : 32'd0;

		if (w.identify_command == ID_START)
			cnt = 32'(ID_LOAD);
		else if (w.identify_command == ID_STOP)
			cnt = 0;

		if (cnt != 0) begin
			if (cfg.manual_mode)
				lv = (cnt > 32'(ID_HIGH_MIN)) ? 32'(ID_MAN_HIGH) : 32'(ID_MAN_LOW);
			else
				lv = (cnt > 32'(ID_HIGH_MIN)) ? 32'(ID_DMX_HIGH) : 32'(ID_DMX_LOW);
			cnt = cnt - 1;
			if (cnt <= 32'(ID_RELOAD))
				cnt = 32'(ID_LOAD);
		end else if (cfg.manual_mode) begin
			if (w.manual_percent >= PCT_FULL)
				lv = 32'(LVL_FULL);
			else
				lv = (int'(w.manual_percent) * int'(LVL_FULL) + 50) / 100;
		end else begin
			dv = 0;
			if (w.dmx_present) begin
				dv = (w.xlr_value > w.eth_value) ? 32'(w.xlr_value) : 32'(w.eth_value);
				held = dv;
			end else if (cfg.worklight_enable && w.worklight_flag) begin
				dv = 32'(DMX_FULL);
			end else if (cfg.hold_last_enable) begin
				dv = held;
			end
			lv = dv * 257;
		end

		if (in_range) begin
			id_count[w.channel] = cnt[CNT_W-1:0];
			held_dmx[w.channel] = held[DMX_W-1:0];
		end

		r.out_channel = w.channel;
		r.level_in = lv[LVL_W-1:0];
		case (w.curve_mode)
			CURVE_OFF: r.level_out = '0;
			CURVE_SQUARE: begin
				sq = (longint'(lv) * longint'(lv) + 32767) / 65535;
				r.level_out = sq[LVL_W-1:0];
			end
			CURVE_SWITCH: r.level_out = (lv >= 32'(LVL_HALF)) ? LVL_FULL : '0;
			CURVE_ON: r.level_out = LVL_FULL;
			default: r.level_out = lv[LVL_W-1:0];
		endcase
		return r;
	endfunction

	function void note_word(item_in_t w);
		expected_levels.push_back(compute_level(w));
	endfunction

	function void check_word(item_out_t got);
		item_out_t exp_w;
		checked++;
		if (expected_levels.size() == 0) begin
			errors++;
			$display("%0t: unexpected result word: ch %0d in %0d out %0d",
				$time, got.out_channel, got.level_in, got.level_out);
			return;
		end
		exp_w = expected_levels.pop_front();
		if (got.out_channel !== exp_w.out_channel) begin
			errors++;
			$display("%0t: out_channel expected %0d actual %0d",
				$time, exp_w.out_channel, got.out_channel);
		end
		if (got.level_in !== exp_w.level_in) begin
			errors++;
			$display("%0t: level_in ch %0d expected %0d actual %0d",
				$time, exp_w.out_channel, exp_w.level_in, got.level_in);
		end
		if (got.level_out !== exp_w.level_out) begin
			errors++;
			$display("%0t: level_out ch %0d expected %0d actual %0d",
				$time, exp_w.out_channel, exp_w.level_out, got.level_out);
		end
	endfunction
endclass

module tb_dimmer_channel_level_select;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;
	localparam int PHASE_WORDS = 125;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit                    quiet;
	int                    cycles;
	int                    words_sent;
	int                    phases;
	level_scoreboard       sb;

	dcls_in_if  chan_if ();
	dcls_out_if res_if ();

	dimmer_channel_level_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.chan      (chan_if),
		.result    (res_if)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_if.ready <= quiet || ($urandom_range(0, 99) >= 26);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (chan_if.valid && chan_if.ready)
				sb.note_word(chan_if.payload);
			if (res_if.valid && res_if.ready)
				sb.check_word(res_if.payload);
		end
	end

	function automatic item_in_t mk(int ch, int xlr, int eth, int pres, int pct,
			logic [CURVE_W-1:0] curve, int wf, logic [CMD_W-1:0] cmd);
		item_in_t w;
		w.channel = CH_W'(ch);
		w.xlr_value = DMX_W'(xlr);
		w.eth_value = DMX_W'(eth);
		w.dmx_present = 1'(pres);
		w.manual_percent = PCT_W'(pct);
		w.curve_mode = curve;
		w.worklight_flag = 1'(wf);
		w.identify_command = cmd;
		return w;
	endfunction

	function automatic logic [DMX_W-1:0] rand_dmx();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return DMX_FULL;
		return DMX_W'($urandom_range(0, 255));
	endfunction

	function automatic item_in_t rand_word();
		item_in_t w;
		int       r;
		r = $urandom_range(0, 99);
		if (r < 60)
			w.channel = CH_W'($urandom_range(0, 1));
		else if (r < 90)
			w.channel = CH_W'($urandom_range(0, CHANNELS_DEF - 1));
		else
			w.channel = CH_W'($urandom_range(CHANNELS_DEF, CH_SPACE - 1));
		w.xlr_value = rand_dmx();
		w.eth_value = rand_dmx();
		w.dmx_present = ($urandom_range(0, 99) < 60);
		if ($urandom_range(0, 99) < 85)
			w.manual_percent = PCT_W'($urandom_range(0, 100));
		else
			w.manual_percent = PCT_W'($urandom_range(101, 127));
		w.curve_mode = CURVE_W'($urandom_range(0, 7));
		w.worklight_flag = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 199);
		if (r < 2)
			w.identify_command = ID_START;
		else if (r < 3)
			w.identify_command = ID_STOP;
		else if (r < 5)
			w.identify_command = 2'd3;
		else
			w.identify_command = ID_KEEP;
		return w;
	endfunction

	task automatic send_word(item_in_t w);
		while (!quiet && $urandom_range(0, 99) < 26) begin
			chan_if.valid <= 1'b0;
			@(posedge clk);
		end
		chan_if.valid <= 1'b1;
		chan_if.payload <= w;
		do
			@(posedge clk);
		while (!chan_if.ready);
		words_sent++;
	endtask

	task automatic drain();
		chan_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_MANUAL_MODE: sb.cfg.manual_mode = val[0];
			CFG_WORKLIGHT_ENABLE: sb.cfg.worklight_enable = val[0];
			CFG_HOLD_LAST_ENABLE: sb.cfg.hold_last_enable = val[0];
			default: ;
		endcase
	endtask

	task automatic set_regs(bit man, bit wl, bit hold);
		drain();
		write_reg(CFG_MANUAL_MODE, man);
		write_reg(CFG_WORKLIGHT_ENABLE, wl);
		write_reg(CFG_HOLD_LAST_ENABLE, hold);
		cfg_we <= 1'b0;
		phases++;
	endtask

	// start identify on one channel and keep feeding it through the low half
	// and past the reload
	task automatic identify_run(int ch, int n);
		item_in_t w;
		w = rand_word();
		w.channel = CH_W'(ch);
		w.identify_command = ID_START;
		send_word(w);
		repeat (n) begin
			w = rand_word();
			w.channel = CH_W'(ch);
			w.identify_command = ID_KEEP;
			send_word(w);
		end
	endtask

	task automatic random_phase(int n);
		repeat (n) send_word(rand_word());
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		chan_if.valid = 1'b0;
		chan_if.payload = '0;
		res_if.ready = 1'b0;
		quiet = 1'b0;
		cycles = 0;
		words_sent = 0;
		phases = 0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: merge, curves, identify, channel range
		set_regs(1'b0, 1'b0, 1'b0);
		send_word(mk(0, 255, 0, 1, 0, CURVE_LINEAR, 0, ID_KEEP));
		send_word(mk(1, 0, 255, 1, 100, CURVE_SQUARE, 1, ID_KEEP));
		send_word(mk(2, 128, 127, 1, 0, CURVE_SWITCH, 0, ID_KEEP));
		send_word(mk(2, 127, 127, 1, 0, CURVE_SWITCH, 0, ID_KEEP));
		send_word(mk(3, 0, 0, 1, 0, CURVE_ON, 0, ID_KEEP));
		send_word(mk(3, 200, 100, 1, 0, CURVE_OFF, 0, ID_KEEP));
		send_word(mk(4, 77, 33, 1, 0, CURVE_SCURVE, 0, ID_KEEP));
		send_word(mk(4, 77, 33, 1, 0, 3'd6, 0, ID_KEEP));
		send_word(mk(4, 1, 254, 1, 0, 3'd7, 0, ID_KEEP));
		send_word(mk(5, 10, 20, 0, 0, CURVE_LINEAR, 1, ID_KEEP));
		send_word(mk(47, 255, 255, 1, 0, CURVE_SQUARE, 0, ID_KEEP));
		send_word(mk(48, 99, 1, 1, 0, CURVE_LINEAR, 0, ID_KEEP));
		send_word(mk(63, 0, 0, 0, 0, CURVE_LINEAR, 0, ID_START));
		send_word(mk(63, 0, 0, 0, 0, CURVE_LINEAR, 0, ID_KEEP));
		send_word(mk(6, 0, 0, 1, 0, CURVE_LINEAR, 0, ID_START));
		send_word(mk(6, 0, 0, 1, 0, CURVE_SQUARE, 0, ID_KEEP));
		send_word(mk(6, 0, 0, 1, 0, CURVE_LINEAR, 0, 2'd3));
		send_word(mk(6, 90, 0, 1, 0, CURVE_LINEAR, 0, ID_STOP));
		// manual percentages, saturation above full
		set_regs(1'b1, 1'b0, 1'b0);
		send_word(mk(8, 0, 0, 0, 0, CURVE_LINEAR, 0, ID_KEEP));
		send_word(mk(8, 0, 0, 0, 100, CURVE_LINEAR, 0, ID_KEEP));
		send_word(mk(8, 0, 0, 0, 101, CURVE_SQUARE, 0, ID_KEEP));
		send_word(mk(8, 0, 0, 0, 127, CURVE_LINEAR, 0, ID_KEEP));
		send_word(mk(9, 0, 0, 0, 50, CURVE_SWITCH, 0, ID_START));
		// worklight then hold-last
		set_regs(1'b0, 1'b1, 1'b1);
		send_word(mk(0, 0, 0, 0, 0, CURVE_LINEAR, 1, ID_KEEP));
		send_word(mk(0, 0, 0, 0, 0, CURVE_LINEAR, 0, ID_KEEP));

		set_regs(1'b0, 1'b0, 1'b0);
		identify_run(5, 110);
		random_phase(PHASE_WORDS);
		set_regs(1'b0, 1'b1, 1'b0);
		random_phase(PHASE_WORDS);
		set_regs(1'b0, 1'b0, 1'b1);
		quiet = 1'b1;
		random_phase(PHASE_WORDS);
		quiet = 1'b0;
		set_regs(1'b0, 1'b1, 1'b1);
		random_phase(PHASE_WORDS);
		set_regs(1'b1, 1'b0, 1'b0);
		identify_run(7, 110);
		random_phase(PHASE_WORDS);
		set_regs(1'b1, 1'b1, 1'b1);
		random_phase(PHASE_WORDS);
		set_regs(1'b0, 1'b0, 1'b1);
		random_phase(PHASE_WORDS);
		drain();

		$display("Sent %0d channel words over %0d register settings, %0d results checked.",
			words_sent, phases, sb.checked);
		if (sb.errors == 0 && sb.expected_levels.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
